FILE: hdl/pidc_pkg.sv
`default_nettype none

package pidc_pkg;

    // Sample and drive width, Q4.12 by default
    localparam int DATA_WIDTH        = 16;
    localparam int FRAC_BITS_DEFAULT = 12;

    localparam int GAIN_W      = 16;
    localparam int LIMIT_W     = 15;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 3;

    // Derived arithmetic widths
    localparam int ERR_W  = DATA_WIDTH + 1;
    localparam int DIFF_W = DATA_WIDTH + 2;
    localparam int SUM_W  = LIMIT_W + 1;
    localparam int SUMX_W = ((SUM_W > ERR_W) ? SUM_W : ERR_W) + 1;
    localparam int OPND_W = (DIFF_W > SUM_W) ? DIFF_W : SUM_W;
    localparam int PROD_W = GAIN_W + 1 + OPND_W;
    localparam int ACC_W  = PROD_W + 2;

    localparam logic [GAIN_W-1:0]  GAIN_P_RESET     = GAIN_W'(4096);
    localparam logic [GAIN_W-1:0]  GAIN_I_RESET     = GAIN_W'(1434);
    localparam logic [GAIN_W-1:0]  GAIN_D_RESET     = GAIN_W'(1024);
    localparam logic [LIMIT_W-1:0] SUM_LIMIT_RESET  = LIMIT_W'(20480);
    localparam logic [LIMIT_W-1:0] OUT_LIMIT_RESET  = LIMIT_W'(4096);
    localparam logic [LIMIT_W-1:0] TOLERANCE_RESET  = LIMIT_W'(4);

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_GAIN_P    = 3'd0,
        CFG_GAIN_I    = 3'd1,
        CFG_GAIN_D    = 3'd2,
        CFG_SUM_LIMIT = 3'd3,
        CFG_OUT_LIMIT = 3'd4,
        CFG_TOLERANCE = 3'd5
    } t_cfg_index;

    typedef struct packed {
        logic [GAIN_W-1:0]  gain_proportional;
        logic [GAIN_W-1:0]  gain_integral;
        logic [GAIN_W-1:0]  gain_derivative;
        logic [LIMIT_W-1:0] sum_limit;
        logic [LIMIT_W-1:0] output_limit;
        logic [LIMIT_W-1:0] settle_tolerance;
    } t_cfg;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] target_value;
        logic signed [DATA_WIDTH-1:0] measured_value;
    } t_in_word;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] drive;
        logic                         settled;
    } t_out_word;

    // Product stage register contents, front to back
    typedef struct packed {
        logic signed [PROD_W-1:0] p_term;
        logic signed [PROD_W-1:0] i_term;
        logic signed [PROD_W-1:0] d_term;
        logic                     settled;
    } t_prod;

endpackage

`default_nettype wire

FILE: hdl/pidc_cfg_regs.sv
`default_nettype none

module pidc_cfg_regs (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [pidc_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  wire logic [pidc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output pidc_pkg::t_cfg                          o_cfg
);

    pidc_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_proportional <= pidc_pkg::GAIN_P_RESET;
            r_cfg.gain_integral     <= pidc_pkg::GAIN_I_RESET;
            r_cfg.gain_derivative   <= pidc_pkg::GAIN_D_RESET;
            r_cfg.sum_limit         <= pidc_pkg::SUM_LIMIT_RESET;
            r_cfg.output_limit      <= pidc_pkg::OUT_LIMIT_RESET;
            r_cfg.settle_tolerance  <= pidc_pkg::TOLERANCE_RESET;
        end else if (i_cfg_we) begin
            case (pidc_pkg::t_cfg_index'(i_cfg_index))
                pidc_pkg::CFG_GAIN_P: begin
                    r_cfg.gain_proportional <= i_cfg_data[pidc_pkg::GAIN_W-1:0];
                end
                pidc_pkg::CFG_GAIN_I: begin
                    r_cfg.gain_integral <= i_cfg_data[pidc_pkg::GAIN_W-1:0];
                end
                pidc_pkg::CFG_GAIN_D: begin
                    r_cfg.gain_derivative <= i_cfg_data[pidc_pkg::GAIN_W-1:0];
                end
                pidc_pkg::CFG_SUM_LIMIT: begin
                    r_cfg.sum_limit <= i_cfg_data[pidc_pkg::LIMIT_W-1:0];
                end
                pidc_pkg::CFG_OUT_LIMIT: begin
                    r_cfg.output_limit <= i_cfg_data[pidc_pkg::LIMIT_W-1:0];
                end
                pidc_pkg::CFG_TOLERANCE: begin
                    r_cfg.settle_tolerance <= i_cfg_data[pidc_pkg::LIMIT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

FILE: hdl/pidc_front.sv
`default_nettype none

// Error, clamped accumulator, derivative difference and the three gain products.
module pidc_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire pidc_pkg::t_in_word i_word,
    input  wire pidc_pkg::t_cfg     i_cfg,
    output logic               o_valid,
    input  wire logic          i_ready,
    output pidc_pkg::t_prod    o_prod
);

    localparam int ERR_W  = pidc_pkg::ERR_W;
    localparam int DIFF_W = pidc_pkg::DIFF_W;
    localparam int SUM_W  = pidc_pkg::SUM_W;
    localparam int SUMX_W = pidc_pkg::SUMX_W;
    localparam int PROD_W = pidc_pkg::PROD_W;
    localparam int GAIN_W = pidc_pkg::GAIN_W;

    logic signed [SUM_W-1:0]  r_error_sum;
    logic signed [ERR_W-1:0]  r_last_error;
    logic                     r_valid;
    pidc_pkg::t_prod          r_prod;

    logic signed [ERR_W-1:0]  err;
    logic signed [SUMX_W-1:0] sum_raw;
    logic signed [SUMX_W-1:0] lim_pos;
    logic signed [SUMX_W-1:0] lim_neg;
    logic signed [SUM_W-1:0]  n_error_sum;
    logic signed [DIFF_W-1:0] diff;
    logic signed [GAIN_W:0]   gp;
    logic signed [GAIN_W:0]   gi;
    logic signed [GAIN_W:0]   gd;
    logic        [ERR_W-1:0]  err_mag;
    logic                     take;
    pidc_pkg::t_prod          n_prod;

    assign err = ERR_W'(i_word.target_value) - ERR_W'(i_word.measured_value);

    // Anti-windup: the clamped sum is what is stored and used
    assign sum_raw = SUMX_W'(r_error_sum) + SUMX_W'(err);
    assign lim_pos = SUMX_W'(signed'({1'b0, i_cfg.sum_limit}));
    assign lim_neg = -lim_pos;

    always_comb begin
        if (sum_raw > lim_pos) begin
            n_error_sum = SUM_W'(lim_pos);
        end else if (sum_raw < lim_neg) begin
            n_error_sum = SUM_W'(lim_neg);
        end else begin
            n_error_sum = SUM_W'(sum_raw);
        end
    end

    assign diff = DIFF_W'(err) - DIFF_W'(r_last_error);

    assign gp = signed'({1'b0, i_cfg.gain_proportional});
    assign gi = signed'({1'b0, i_cfg.gain_integral});
    assign gd = signed'({1'b0, i_cfg.gain_derivative});

    assign err_mag = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);

    always_comb begin
        n_prod.p_term  = PROD_W'(gp) * PROD_W'(err);
        n_prod.i_term  = PROD_W'(gi) * PROD_W'(n_error_sum);
        n_prod.d_term  = PROD_W'(gd) * PROD_W'(diff);
        n_prod.settled = (err_mag <= i_cfg.settle_tolerance);
    end

    assign o_ready = !r_valid || i_ready;
    assign take    = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_error_sum  <= '0;
            r_last_error <= '0;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (take) begin
                r_error_sum  <= n_error_sum;
                r_last_error <= err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_prod <= n_prod;
        end
    end

    assign o_valid = r_valid;
    assign o_prod  = r_prod;

endmodule

`default_nettype wire

FILE: hdl/pidc_back.sv
`default_nettype none

// Sum of products, round half up, saturate, result register.
module pidc_back #(
    parameter int FRAC_BITS = pidc_pkg::FRAC_BITS_DEFAULT
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire pidc_pkg::t_prod i_prod,
    input  wire logic [pidc_pkg::LIMIT_W-1:0] i_output_limit,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output pidc_pkg::t_out_word  o_word
);

    localparam int ACC_W = pidc_pkg::ACC_W;
    localparam int DW    = pidc_pkg::DATA_WIDTH;
    localparam logic signed [ACC_W-1:0] RoundHalf =
        {{(ACC_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

    logic                    r_valid;
    pidc_pkg::t_out_word     r_word;

    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] scaled;
    logic signed [ACC_W-1:0] lim_pos;
    logic signed [ACC_W-1:0] lim_neg;
    logic signed [ACC_W-1:0] sat;
    pidc_pkg::t_out_word     n_word;
    logic                    take;

    assign acc = ACC_W'(i_prod.p_term) + ACC_W'(i_prod.i_term)
               + ACC_W'(i_prod.d_term) + RoundHalf;
    assign scaled  = acc >>> FRAC_BITS;
    assign lim_pos = ACC_W'(signed'({1'b0, i_output_limit}));
    assign lim_neg = -lim_pos;

    always_comb begin
        if (scaled > lim_pos) begin
            sat = lim_pos;
        end else if (scaled < lim_neg) begin
            sat = lim_neg;
        end else begin
            sat = scaled;
        end
        n_word.drive   = sat[DW-1:0];
        n_word.settled = i_prod.settled;
    end

    assign o_ready = !r_valid || i_ready;
    assign take    = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

`default_nettype wire

FILE: hdl/pid_controller_antiwindup_top.sv
// PID regulator with a clamped integral term. Each input word (target, measured, signed
// Q4.12) yields one output word: drive = kp*e + ki*sum + kd*(e - e_prev), rounded half up
// and saturated to +-output_limit, plus a settled flag when |e| <= settle_tolerance. The
// sum is clamped to +-sum_limit before use. One word per clock is sustained while the
// output is ready; a result passes through the input, product and result registers, the
// first loaded on the accepting edge. Accumulator and last-error updates are the
// cycle-to-cycle loops and sit in the product stage. The user must write registers
// through the config port only while no word is in flight; the block doesn't enforce it.
`default_nettype none

module pid_controller_antiwindup_top #(
    parameter int FRAC_BITS = pidc_pkg::FRAC_BITS_DEFAULT
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire pidc_pkg::t_in_word               i_in_word,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output pidc_pkg::t_out_word                   o_out_word,
    input  wire logic                             i_cfg_we,
    input  wire logic [pidc_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [pidc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    pidc_pkg::t_cfg     cfg;
    logic               r_in_valid;
    pidc_pkg::t_in_word r_in_word;
    logic               front_ready;
    logic               prod_valid;
    pidc_pkg::t_prod    prod;
    logic               back_ready;

    pidc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    assign o_in_ready = !r_in_valid || front_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_word <= i_in_word;
        end
    end

    pidc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_valid),
        .o_ready (front_ready),
        .i_word  (r_in_word),
        .i_cfg   (cfg),
        .o_valid (prod_valid),
        .i_ready (back_ready),
        .o_prod  (prod)
    );

    pidc_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (prod_valid),
        .o_ready        (back_ready),
        .i_prod         (prod),
        .i_output_limit (cfg.output_limit),
        .o_valid        (o_out_valid),
        .i_ready        (i_out_ready),
        .o_word         (o_out_word)
    );

endmodule

`default_nettype wire

FILE: verif/tb_pid_controller_antiwindup_top.sv
module tb_pid_controller_antiwindup_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pidc_pkg::*;

    localparam int PIPE_LATENCY    = 3;
    localparam int WATCHDOG_CYCLES = 2000;
    localparam int RAND_PHASES     = 12;
    localparam int PHASE_ITEMS     = 160;
    localparam int FRAC            = FRAC_BITS_DEFAULT;
    localparam longint ROUND_HALF  = longint'(1) << (FRAC - 1);

    // indexes past the register map; writes there must be dropped
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_B = 3'd7;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_ready;
    t_in_word               i_in_word;
    logic                   o_out_valid;
    logic                   i_out_ready;
    t_out_word              o_out_word;
    logic                   i_cfg_we;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    // predictor copy of registers and loop state
    logic [GAIN_W-1:0]  gain_p;
    logic [GAIN_W-1:0]  gain_i;
    logic [GAIN_W-1:0]  gain_d;
    logic [LIMIT_W-1:0] sum_lim;
    logic [LIMIT_W-1:0] out_lim;
    logic [LIMIT_W-1:0] settle_tol;
    longint             int_sum;
    longint             last_err;

    t_out_word pending_drive_q[$];
    logic [DATA_WIDTH-1:0] setpoint;

    bit bursts_on;
    int mismatches;
    int samples_sent;
    int drives_checked;
    int settings_applied;
    int settled_seen;
    int clipped_seen;
    int stall_left;

    pid_controller_antiwindup_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void reset_model();
        gain_p     = GAIN_P_RESET;
        gain_i     = GAIN_I_RESET;
        gain_d     = GAIN_D_RESET;
        sum_lim    = SUM_LIMIT_RESET;
        out_lim    = OUT_LIMIT_RESET;
        settle_tol = TOLERANCE_RESET;
        int_sum    = 0;
        last_err   = 0;
    endfunction

    // one regulator step: clamped sum, three products, round half up, saturate
    function automatic t_out_word compute_drive(input t_in_word w);
        longint    err;
        longint    diff;
        longint    acc;
        longint    drv;
        longint    lim;
        longint    mag;
        t_out_word res;
        err  = longint'($signed(w.target_value)) - longint'($signed(w.measured_value));
        diff = err - last_err;
        lim  = longint'(sum_lim);
        int_sum = int_sum + err;
        if (int_sum > lim) begin
            int_sum = lim;
        end else if (int_sum < -lim) begin
            int_sum = -lim;
        end
        acc = longint'(gain_p) * err + longint'(gain_i) * int_sum
            + longint'(gain_d) * diff + ROUND_HALF;
        drv = acc >>> FRAC;
        lim = longint'(out_lim);
        if (drv > lim) begin
            drv = lim;
            clipped_seen++;
        end else if (drv < -lim) begin
            drv = -lim;
            clipped_seen++;
        end
        last_err = err;
        mag = (err < 0) ? -err : err;
        res.drive   = drv[DATA_WIDTH-1:0];
        res.settled = (mag <= longint'(settle_tol));
        if (res.settled) begin
            settled_seen++;
        end
        return res;
    endfunction

    function automatic t_in_word make_sample(input logic [DATA_WIDTH-1:0] t,
                                             input logic [DATA_WIDTH-1:0] m);
        t_in_word res;
        res.target_value   = t;
        res.measured_value = m;
        return res;
    endfunction

    function automatic logic [DATA_WIDTH-1:0] pick_edge();
        case ($urandom_range(0, 4))
            0: return 16'h8000;
            1: return 16'hFFFF;
            2: return 16'h0000;
            3: return 16'h0001;
            default: return 16'h7FFF;
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_gain();
        if ($urandom_range(0, 3) == 0) begin
            return CFG_DATA_W'($urandom_range(0, 65535));
        end
        return CFG_DATA_W'($urandom_range(0, 8192));
    endfunction

    // bit 15 is random too; the block must mask it off
    function automatic logic [CFG_DATA_W-1:0] pick_limit();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return 16'h7FFF;
            2: return CFG_DATA_W'($urandom_range(0, 64));
            default: return CFG_DATA_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // half the time a loop tracking a setpoint that moves now and then, else edge or random values
    function automatic t_in_word random_sample();
        int kind;
        logic [DATA_WIDTH-1:0] delta;
        kind = $urandom_range(0, 9);
        if (kind < 5) begin
            if ($urandom_range(0, 19) == 0) begin
                setpoint = DATA_WIDTH'($urandom);
            end
            delta = DATA_WIDTH'($urandom_range(0, 64)) - DATA_WIDTH'(32);
            return make_sample(setpoint, setpoint - delta);
        end else if (kind < 7) begin
            return make_sample(pick_edge(), pick_edge());
        end
        return make_sample(DATA_WIDTH'($urandom), DATA_WIDTH'($urandom));
    endfunction

    task automatic flag_error(input string msg);
        mismatches++;
        if (mismatches <= 10) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endtask

    task automatic send_sample(input t_in_word w);
        if (bursts_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        pending_drive_q.push_back(compute_drive(w));
        samples_sent++;
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_drive_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY + 1) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            CFG_GAIN_P:    gain_p     = data;
            CFG_GAIN_I:    gain_i     = data;
            CFG_GAIN_D:    gain_d     = data;
            CFG_SUM_LIMIT: sum_lim    = data[LIMIT_W-1:0];
            CFG_OUT_LIMIT: out_lim    = data[LIMIT_W-1:0];
            CFG_TOLERANCE: settle_tol = data[LIMIT_W-1:0];
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_settings(input logic [CFG_DATA_W-1:0] gp, input logic [CFG_DATA_W-1:0] gi,
                                  input logic [CFG_DATA_W-1:0] gd, input logic [CFG_DATA_W-1:0] sl,
                                  input logic [CFG_DATA_W-1:0] ol, input logic [CFG_DATA_W-1:0] tol);
        drain_results();
        write_reg(CFG_GAIN_P, gp);
        write_reg(CFG_GAIN_I, gi);
        write_reg(CFG_GAIN_D, gd);
        write_reg(CFG_SUM_LIMIT, sl);
        write_reg(CFG_OUT_LIMIT, ol);
        write_reg(CFG_TOLERANCE, tol);
        settings_applied++;
    endtask

    // registers as they come out of reset: settle band edges, windup and clipping
    task automatic test_reset_values();
        send_sample(make_sample(16'sd0, 16'sd0));
        send_sample(make_sample(16'sd4, 16'sd0));
        send_sample(make_sample(16'sd0, 16'sd4));
        send_sample(make_sample(16'sd5, 16'sd0));
        send_sample(make_sample(16'sd0, 16'sd5));
        send_sample(make_sample(16'h7FFF, 16'h8000));
        send_sample(make_sample(16'h7FFF, 16'h8000));
        send_sample(make_sample(16'h8000, 16'h7FFF));
        send_sample(make_sample(16'h8000, 16'h8000));
    endtask

    // half-LSB ties must round towards plus infinity
    task automatic test_rounding_ties();
        apply_settings(16'd2048, 16'd0, 16'd0, 16'd0, 16'h7FFF, 16'd0);
        send_sample(make_sample(16'sd1, 16'sd0));
        send_sample(make_sample(-16'sd1, 16'sd0));
        send_sample(make_sample(16'sd3, 16'sd0));
        send_sample(make_sample(-16'sd3, 16'sd0));
        send_sample(make_sample(16'sd0, 16'sd0));
    endtask

    task automatic test_derivative_swing();
        apply_settings(16'd0, 16'd0, 16'hFFFF, 16'd0, 16'h7FFF, 16'd0);
        send_sample(make_sample(16'sd0, 16'sd0));
        send_sample(make_sample(16'h7FFF, 16'h8000));
        send_sample(make_sample(16'h8000, 16'h7FFF));
        send_sample(make_sample(16'sd1, 16'sd0));
        send_sample(make_sample(16'sd1, 16'sd0));
    endtask

    task automatic test_zero_limits();
        apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'd0);
        send_sample(make_sample(16'sd100, 16'sd0));
        send_sample(make_sample(-16'sd100, 16'sd0));
        send_sample(make_sample(16'sd0, 16'sd0));
    endtask

    // top bit of the limit registers is dropped, spare indexes do nothing
    task automatic test_register_masking();
        apply_settings(16'd4096, 16'd2048, 16'd512, 16'hFFFF, 16'hFFFF, 16'h8010);
        write_reg(CFG_SPARE_A, 16'h0000);
        write_reg(CFG_SPARE_B, 16'h7FFF);
        send_sample(make_sample(16'sd16, 16'sd0));
        send_sample(make_sample(16'sd0, 16'sd17));
        send_sample(make_sample(16'h7FFF, 16'h8000));
    endtask

    task automatic test_random_phases();
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0: begin
                    apply_settings(CFG_DATA_W'(GAIN_P_RESET), CFG_DATA_W'(GAIN_I_RESET),
                                   CFG_DATA_W'(GAIN_D_RESET), CFG_DATA_W'(SUM_LIMIT_RESET),
                                   CFG_DATA_W'(OUT_LIMIT_RESET), CFG_DATA_W'(TOLERANCE_RESET));
                end
                1: begin
                    apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                end
                2: begin
                    apply_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'h7FFF);
                end
                default: begin
                    apply_settings(pick_gain(), pick_gain(), pick_gain(),
                                   pick_limit(), pick_limit(), pick_limit());
                end
            endcase
            bursts_on = (ph != RAND_PHASES - 1);
            setpoint  = DATA_WIDTH'($urandom);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                // let the pipe run dry mid-phase now and then
                if (k == PHASE_ITEMS / 2 && ph % 3 == 1) begin
                    drain_results();
                end
                send_sample(random_sample());
            end
        end
    endtask

    // result checker and sink-side stalls
    always @(posedge i_clk) begin : drive_sink
        t_out_word exp_word;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (pending_drive_q.size() == 0) begin
                flag_error($sformatf("unexpected word drive=%0d settled=%0b",
                                     $signed(o_out_word.drive), o_out_word.settled));
            end else begin
                exp_word = pending_drive_q.pop_front();
                drives_checked++;
                if (o_out_word.drive !== exp_word.drive ||
                    o_out_word.settled !== exp_word.settled) begin
                    flag_error($sformatf("drive exp %0d got %0d, settled exp %0b got %0b",
                                         $signed(exp_word.drive), $signed(o_out_word.drive),
                                         exp_word.settled, o_out_word.settled));
                end
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (bursts_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 4);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_CYCLES) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_in_valid && o_in_ready === 1'b1) ||
                (o_out_valid === 1'b1 && i_out_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("watchdog: no word moved for %0d cycles", WATCHDOG_CYCLES);
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_word   = '0;
        i_out_ready = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        bursts_on   = 1'b1;
        stall_left  = 0;
        setpoint    = '0;
        reset_model();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_values();
        test_rounding_ties();
        test_derivative_swing();
        test_zero_limits();
        test_register_masking();
        test_random_phases();

        drain_results();
        repeat (PIPE_LATENCY + 4) @(posedge i_clk);

        $display("Ran %0d samples under %0d register settings, %0d drives checked.",
                 samples_sent, settings_applied + 1, drives_checked);
        $display("Of those, %0d were settled and %0d clipped at the output limit.",
                 settled_seen, clipped_seen);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches in total", mismatches);
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

FILE: files.f
hdl/pidc_pkg.sv
hdl/pidc_cfg_regs.sv
hdl/pidc_front.sv
hdl/pidc_back.sv
hdl/pid_controller_antiwindup_top.sv
verif/tb_pid_controller_antiwindup_top.sv
